[rtl/valloc_pkg.sv]
// Shared types, codes and constants of the voice allocator.
package valloc_pkg;

    localparam int VOICE_COUNT_DEF = 16;
    localparam int VOICE_MAX       = 64;
    localparam int IDX_W           = 6;
    localparam int CNT_W           = 7;
    localparam int STAMP_W         = 32;
    localparam int NOTE_W          = 7;
    localparam int MASK_W          = 16;
    localparam int BCNT_W          = 5;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 7;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_MONO_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TRANSPOSE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOUND_LOADED = 2'd2;

    typedef enum logic [1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_FINISHED = 2'd2,
        ACT_STOP_ALL = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SCAN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic [IDX_W-1:0]   old_idx;
        logic [STAMP_W-1:0] old_stamp;
        logic [CNT_W-1:0]   count;
    } t_scan_rec;

    typedef struct packed {
        logic               clr;
        logic               wr;
        logic [STAMP_W-1:0] stamp;
    } t_cell_cmd;

endpackage

[rtl/valloc_cell.sv]
// One voice cell: holds busy flag and age stamp and updates the passing search record.
module valloc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  valloc_pkg::t_cell_cmd i_cmd,
    input  valloc_pkg::t_scan_rec i_rec,
    input  logic                  i_rec_valid,
    output valloc_pkg::t_scan_rec o_rec,
    output logic                  o_rec_valid,
    output logic                  o_busy
);
    import valloc_pkg::*;

    logic               r_busy;
    logic [STAMP_W-1:0] r_stamp;
    t_scan_rec          r_rec;
    t_scan_rec          n_rec;
    logic               r_rec_valid;

    always_comb begin
        n_rec       = i_rec;
        n_rec.count = i_rec.count + CNT_W'(r_busy);
        if (!r_busy && !i_rec.free_found) begin
            n_rec.free_found = 1'b1;
            n_rec.free_idx   = IDX_W'(CELL_INDEX);
        end
        if (r_busy && (r_stamp < i_rec.old_stamp)) begin
            n_rec.old_idx   = IDX_W'(CELL_INDEX);
            n_rec.old_stamp = r_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rec_valid <= 1'b0;
        end else begin
            r_rec_valid <= i_rec_valid;
            if (i_cmd.wr) begin
                r_busy <= 1'b1;
            end else if (i_cmd.clr) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_stamp <= i_cmd.stamp;
        end
        if (i_rec_valid) begin
            r_rec <= n_rec;
        end
    end

    assign o_rec       = r_rec;
    assign o_rec_valid = r_rec_valid;
    assign o_busy      = r_busy;

endmodule

[rtl/voice_allocator_oldest_steal_top.sv]
// Top level of the voice allocator with oldest-voice stealing.
// A transaction is taken only in the idle state. Its search record then walks the chain
// of voice cells one cell per cycle, and the result is captured and committed to the
// output register; no new transaction is taken before the commit, and a result still
// waiting holds the commit.
// Reset: synchronous active-low; voices free; stamp counter, state and config zero.
module voice_allocator_oldest_steal_top #(
    parameter int VOICE_COUNT = valloc_pkg::VOICE_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // note_number [6:0], velocity [13:7], finished_voice [17:14], zero fill above
    input  logic [valloc_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // action [1:0]
    input  logic [1:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // start_valid [0], start_voice [4:1], start_note [11:5], start_velocity [18:12],
    // stolen [19], stop_mask [35:20], release_mask [51:36], busy_count [56:52]
    output logic [valloc_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                              i_cfg_we,
    input  logic [valloc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [valloc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import valloc_pkg::*;

    logic              r_mono;
    logic [NOTE_W-1:0] r_transpose;
    logic              r_loaded;

    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_launch;
    logic   w_commit;

    t_scan_rec               w_rec [0:VOICE_COUNT];
    logic [VOICE_COUNT:0]    w_vld;
    t_cell_cmd               w_cmd [0:VOICE_COUNT-1];
    logic [VOICE_COUNT-1:0]  w_busy;
    logic [MASK_W-1:0]       w_mask;

    t_action           w_act;
    logic [NOTE_W-1:0] w_in_note;
    logic [NOTE_W-1:0] w_in_vel;
    logic [3:0]        w_in_fin;
    logic [8:0]        w_sum;
    logic [NOTE_W-1:0] w_note_sat;
    logic              w_start_in;
    logic              w_clear_all;

    logic              r_start_en;
    logic [NOTE_W-1:0] r_note;
    logic [NOTE_W-1:0] r_vel;
    logic [MASK_W-1:0] r_stop_mask;
    logic [MASK_W-1:0] r_rel_mask;
    logic [STAMP_W-1:0] r_stamp_ctr;

    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_idx;
    logic [IDX_W-1:0]  r_old_idx;
    logic [CNT_W-1:0]  r_count;

    logic [IDX_W-1:0]  w_target;
    logic              w_stolen;
    logic [CNT_W-1:0]  w_cnt_new;
    logic [BCNT_W-1:0] w_cnt_sat;
    logic [STAMP_W-1:0] w_stamp_next;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono      <= 1'b0;
            r_transpose <= '0;
            r_loaded    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MONO_MODE:    r_mono      <= i_cfg_wdata[0];
                CFG_TRANSPOSE:    r_transpose <= i_cfg_wdata;
                CFG_SOUND_LOADED: r_loaded    <= i_cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Input decode.
    assign w_act      = t_action'(i_s_tuser);
    assign w_in_note  = i_s_tdata[6:0];
    assign w_in_vel   = i_s_tdata[13:7];
    assign w_in_fin   = i_s_tdata[17:14];
    assign w_sum      = $signed({2'b00, w_in_note}) + $signed({{2{r_transpose[6]}}, r_transpose});
    assign w_note_sat = w_sum[8] ? '0 : (w_sum[7] ? 7'd127 : w_sum[6:0]);
    assign w_start_in = (w_act == ACT_NOTE_ON) && r_loaded;
    assign w_clear_all = w_accept && ((w_start_in && r_mono) || (w_act == ACT_STOP_ALL));

    // State machine.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_SCAN;
            ST_SCAN:   if (w_vld[VOICE_COUNT]) n_state = ST_WRITE;
            ST_WRITE:  if (w_commit) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_launch   = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_s_tready = 1'b1;
            ST_LAUNCH: w_launch   = 1'b1;
            ST_SCAN:   ;
            ST_WRITE:  w_commit   = !r_out_valid || i_m_tready;
            default:   ;
        endcase
    end

    assign w_accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Busy mask seen on the 16-bit mask fields.
    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < VOICE_COUNT) begin : g_on
            assign w_mask[b] = w_busy[b];
        end else begin : g_off
            assign w_mask[b] = 1'b0;
        end
    end

    // Transaction and search result capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_start_en  <= w_start_in;
            r_note      <= w_note_sat;
            r_vel       <= w_in_vel;
            r_stop_mask <= ((w_start_in && r_mono) || (w_act == ACT_STOP_ALL)) ? w_mask : '0;
            r_rel_mask  <= (w_act == ACT_NOTE_OFF) ? w_mask : '0;
        end
        if ((r_state == ST_SCAN) && w_vld[VOICE_COUNT]) begin
            r_free_found <= w_rec[VOICE_COUNT].free_found;
            r_free_idx   <= w_rec[VOICE_COUNT].free_idx;
            r_old_idx    <= w_rec[VOICE_COUNT].old_idx;
            r_count      <= w_rec[VOICE_COUNT].count;
        end
    end

    // Chain of voice cells.
    always_comb begin
        w_rec[0].free_found = 1'b0;
        w_rec[0].free_idx   = '0;
        w_rec[0].old_idx    = '0;
        w_rec[0].old_stamp  = '1;
        w_rec[0].count      = '0;
    end
    assign w_vld[0] = w_launch;

    assign w_stolen     = !r_free_found;
    assign w_target     = w_stolen ? r_old_idx : r_free_idx;
    assign w_stamp_next = r_stamp_ctr + STAMP_W'(1);

    for (genvar c = 0; c < VOICE_COUNT; c++) begin : g_cell
        always_comb begin
            w_cmd[c].clr   = w_clear_all ||
                             (w_accept && (w_act == ACT_FINISHED) &&
                              ({3'b000, w_in_fin} == CNT_W'(c)));
            w_cmd[c].wr    = w_commit && r_start_en && (w_target == IDX_W'(c));
            w_cmd[c].stamp = w_stamp_next;
        end

        valloc_cell #(
            .CELL_INDEX(c)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd[c]),
            .i_rec       (w_rec[c]),
            .i_rec_valid (w_vld[c]),
            .o_rec       (w_rec[c+1]),
            .o_rec_valid (w_vld[c+1]),
            .o_busy      (w_busy[c])
        );
    end

    // Commit and result register.
    assign w_cnt_new = r_count + CNT_W'(r_start_en && r_free_found);
    assign w_cnt_sat = (w_cnt_new > CNT_W'(31)) ? BCNT_W'(31) : w_cnt_new[BCNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp_ctr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
                if (r_start_en) begin
                    r_stamp_ctr <= w_stamp_next;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data[0]     <= r_start_en;
            r_out_data[4:1]   <= r_start_en ? w_target[3:0] : 4'd0;
            r_out_data[11:5]  <= r_start_en ? r_note : '0;
            r_out_data[18:12] <= r_start_en ? r_vel : '0;
            r_out_data[19]    <= r_start_en && w_stolen;
            r_out_data[35:20] <= r_stop_mask;
            r_out_data[51:36] <= r_rel_mask;
            r_out_data[56:52] <= w_cnt_sat;
            r_out_data[63:57] <= '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks.
    a_one_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one search record in the cell chain");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tdata[56:52] != 5'd0))
        else $error("voice started but busy count is zero");

    a_stolen_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[19]) |-> (o_m_tdata[0] && (o_m_tdata[35:20] == 16'd0)))
        else $error("stolen voice without a start or with a hard stop");

    a_scan_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && !w_vld[VOICE_COUNT]) |=> (r_state == ST_SCAN))
        else $error("scan left before the record reached the last cell");

endmodule
